FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the keyed packet store.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset
`define KPSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold
`define KPSA_NEVER(lbl, cond, msg) \
  `KPSA_ASSERT(lbl, !(cond), msg)

`endif

FILE: hw/rtl/kpsa_pkg.sv
// Package of the keyed packet store: sizes, codes, record and bin words,
// command and status structs and the key hash. No dependencies.
package kpsa_pkg;

  localparam int RECORD_COUNT   = 32;
  localparam int BIN_DEPTH      = 8;
  localparam int QUERY_LIMIT    = 8;
  localparam int BIN_INDEX_BITS = 10;
  localparam int KEY_BYTES      = 8;

  localparam int KEY_W   = 64;
  localparam int LEN_W   = 4;
  localparam int SLOT_W  = 12;
  localparam int TIME_W  = 32;
  localparam int TMO_W   = 16;
  localparam int EXP_W   = TIME_W + 1;
  localparam int ID_W    = 5;
  localparam int LINK_W  = 6;
  localparam int FILL_W  = $clog2(BIN_DEPTH + 1);
  localparam int CNT_W   = 4;
  localparam int BIN_COUNT = 1 << BIN_INDEX_BITS;

  localparam logic [LINK_W-1:0] NONE_REC = {LINK_W{1'b1}};

  localparam logic [1:0] KIND_SAVE  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;

  typedef enum logic [2:0] {
    EV_EXPIRED   = 3'd0,
    EV_SAVED     = 3'd1,
    EV_UNINDEXED = 3'd2,
    EV_NO_FREE   = 3'd3,
    EV_MATCH     = 3'd4,
    EV_QDONE     = 3'd5,
    EV_FREED     = 3'd6,
    EV_NOT_USED  = 3'd7
  } event_e;

  // one stored record
  typedef struct packed {
    logic [EXP_W-1:0]  expiry;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic [KEY_W-1:0]  key;
  } rec_t;

  // one hash bin: fill count and member ids
  typedef struct packed {
    logic [FILL_W-1:0]                   fill;
    logic [BIN_DEPTH-1:0][ID_W-1:0]      members;
  } bin_t;

  localparam int REC_WORD_W = $bits(rec_t);
  localparam int BIN_WORD_W = $bits(bin_t);

  // controller to datapath
  typedef struct packed {
    logic   clr_step;
    logic   load_in;
    logic   rd_head;
    logic   rd_rid;
    logic   latch_rm;
    logic   rm_link;
    logic   rm_bin;
    logic   save_alloc;
    logic   sv_bin;
    logic   q_rd;
    logic   q_load;
    logic   q_rd_rec;
    logic   q_skip;
    logic   q_hit;
    logic   emit;
    event_e ev;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clr_last;
    logic [1:0] kind;
    logic       head_none;
    logic       expired;
    logic       rid_used;
    logic       free_found;
    logic       bin_full;
    logic       q_more;
    logic       q_used;
    logic       q_match;
    logic       out_free;
  } dp_stat_t;

  // clamp key length to 1..KEY_BYTES
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] l;
    l = raw;
    if (raw == '0) l = LEN_W'(1);
    if (raw > LEN_W'(KEY_BYTES)) l = LEN_W'(KEY_BYTES);
    return l;
  endfunction

  // keep the valid key bytes only
  function automatic logic [KEY_W-1:0] key_mask(input logic [KEY_W-1:0] key,
                                                input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (LEN_W'(i) < len) m[8*i +: 8] = 8'hFF;
    end
    return key & m;
  endfunction

  // XOR of 16-bit words, odd last byte added sign extended, low bits taken
  function automatic logic [BIN_INDEX_BITS-1:0] bin_of(input logic [KEY_W-1:0] key,
                                                       input logic [LEN_W-1:0] len);
    logic [15:0]      h;
    logic [7:0]       b;
    logic [LEN_W-1:0] half;
    h    = '0;
    b    = '0;
    half = len >> 1;
    for (int i = 0; i < KEY_BYTES / 2; i++) begin
      if (LEN_W'(i) < half) h = h ^ key[16*i +: 16];
    end
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (LEN_W'(i) == len - LEN_W'(1)) b = key[8*i +: 8];
    end
    if (len[0]) h = h + {{8{b[7]}}, b};
    return h[BIN_INDEX_BITS-1:0];
  endfunction

endpackage

FILE: hw/rtl/kpsa_if.sv
// Handshake interfaces for the input word and the result word.
// Depends on kpsa_pkg for field widths.
interface kpsa_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [kpsa_pkg::KEY_W-1:0]     key;
  logic [kpsa_pkg::LEN_W-1:0]     key_len;
  logic [kpsa_pkg::SLOT_W-1:0]    packet_slot;
  logic [kpsa_pkg::TIME_W-1:0]    now;
  logic [kpsa_pkg::TMO_W-1:0]     timeout_secs;
  logic [kpsa_pkg::ID_W-1:0]      record_id;

  modport source (output valid, kind, key, key_len, packet_slot, now, timeout_secs,
                  record_id, input ready);
  modport sink   (input valid, kind, key, key_len, packet_slot, now, timeout_secs,
                  record_id, output ready);
endinterface

interface kpsa_out_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     event_res;
  logic [kpsa_pkg::ID_W-1:0]      result_record;
  logic [kpsa_pkg::SLOT_W-1:0]    result_slot;
  logic [kpsa_pkg::CNT_W-1:0]     match_count;
  logic                           last;

  modport source (output valid, event_res, result_record, result_slot, match_count, last,
                  input ready);
  modport sink   (input valid, event_res, result_record, result_slot, match_count, last,
                  output ready);
endinterface

FILE: hw/rtl/kpsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // read port, data held until next read
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/kpsa_ctrl.sv
// Sequencing state machine of the keyed packet store.
// Depends on kpsa_pkg; drives kpsa_dp through ctrl_cmd_t.
module kpsa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_kind_i,
  output logic                 in_ready_o,
  input  kpsa_pkg::dp_stat_t   stat_i,
  output kpsa_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_EXP  = 4'd2;
  localparam logic [3:0] S_RDW  = 4'd3;
  localparam logic [3:0] S_RML  = 4'd4;
  localparam logic [3:0] S_RMB  = 4'd5;
  localparam logic [3:0] S_FIND = 4'd6;
  localparam logic [3:0] S_SVB  = 4'd7;
  localparam logic [3:0] S_QRD  = 4'd8;
  localparam logic [3:0] S_QLD  = 4'd9;
  localparam logic [3:0] S_QNX  = 4'd10;
  localparam logic [3:0] S_QCMP = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;
  localparam logic [3:0] S_FRC  = 4'd13;

  logic [3:0] state_q, state_d;
  logic       is_save;

  assign is_save = (stat_i.kind == kpsa_pkg::KIND_SAVE);

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.ev   = kpsa_pkg::EV_EXPIRED;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          case (in_kind_i)
            kpsa_pkg::KIND_SAVE:  state_d = S_EXP;
            kpsa_pkg::KIND_QUERY: state_d = S_QRD;
            kpsa_pkg::KIND_FREE:  state_d = S_FRC;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_FRC: begin
        if (stat_i.rid_used) begin
          cmd_o.rd_rid = 1'b1;
          state_d      = S_RDW;
        end else begin
          state_d = S_DONE;
        end
      end
      S_EXP: begin
        if (stat_i.head_none) begin
          state_d = S_FIND;
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d       = S_RDW;
        end
      end
      S_RDW: begin
        cmd_o.latch_rm = 1'b1;
        if (is_save && !stat_i.expired) state_d = S_FIND;
        else                            state_d = S_RML;
      end
      S_RML: begin
        cmd_o.rm_link = 1'b1;
        state_d       = S_RMB;
      end
      S_RMB: begin
        cmd_o.ev = is_save ? kpsa_pkg::EV_EXPIRED : kpsa_pkg::EV_FREED;
        if (stat_i.out_free) begin
          cmd_o.rm_bin = 1'b1;
          cmd_o.emit   = 1'b1;
          state_d      = is_save ? S_EXP : S_IDLE;
        end
      end
      S_FIND: begin
        cmd_o.ev = kpsa_pkg::EV_NO_FREE;
        if (stat_i.free_found) begin
          cmd_o.save_alloc = 1'b1;
          state_d          = S_SVB;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_SVB: begin
        cmd_o.ev = stat_i.bin_full ? kpsa_pkg::EV_UNINDEXED : kpsa_pkg::EV_SAVED;
        if (stat_i.out_free) begin
          cmd_o.sv_bin = 1'b1;
          cmd_o.emit   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_QRD: begin
        cmd_o.q_rd = 1'b1;
        state_d    = S_QLD;
      end
      S_QLD: begin
        cmd_o.q_load = 1'b1;
        state_d      = S_QNX;
      end
      S_QNX: begin
        if (!stat_i.q_more) begin
          state_d = S_DONE;
        end else if (stat_i.q_used) begin
          cmd_o.q_rd_rec = 1'b1;
          state_d        = S_QCMP;
        end else begin
          cmd_o.q_skip = 1'b1;
        end
      end
      S_QCMP: begin
        cmd_o.ev = kpsa_pkg::EV_MATCH;
        if (!stat_i.q_match) begin
          cmd_o.q_skip = 1'b1;
          state_d      = S_QNX;
        end else if (stat_i.out_free) begin
          cmd_o.q_hit = 1'b1;
          cmd_o.emit  = 1'b1;
          state_d     = S_QNX;
        end
      end
      S_DONE: begin
        cmd_o.ev = (stat_i.kind == kpsa_pkg::KIND_QUERY) ? kpsa_pkg::EV_QDONE
                                                          : kpsa_pkg::EV_NOT_USED;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/kpsa_dp.sv
// Datapath of the keyed packet store: record and bin memories, age list,
// working registers and the result register. Depends on kpsa_pkg, kpsa_ram, assert_macros.svh.
`include "assert_macros.svh"

module kpsa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kpsa_pkg::ctrl_cmd_t           cmd_i,
  output kpsa_pkg::dp_stat_t            stat_o,
  input  logic [1:0]                    kind_i,
  input  logic [kpsa_pkg::KEY_W-1:0]    key_i,
  input  logic [kpsa_pkg::LEN_W-1:0]    key_len_i,
  input  logic [kpsa_pkg::SLOT_W-1:0]   packet_slot_i,
  input  logic [kpsa_pkg::TIME_W-1:0]   now_i,
  input  logic [kpsa_pkg::TMO_W-1:0]    timeout_secs_i,
  input  logic [kpsa_pkg::ID_W-1:0]     record_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    event_res_o,
  output logic [kpsa_pkg::ID_W-1:0]     result_record_o,
  output logic [kpsa_pkg::SLOT_W-1:0]   result_slot_o,
  output logic [kpsa_pkg::CNT_W-1:0]    match_count_o,
  output logic                          last_o
);

  localparam int RC    = kpsa_pkg::RECORD_COUNT;
  localparam int BD    = kpsa_pkg::BIN_DEPTH;
  localparam int ID_W  = kpsa_pkg::ID_W;
  localparam int LW    = kpsa_pkg::LINK_W;
  localparam int FW    = kpsa_pkg::FILL_W;
  localparam int BIB   = kpsa_pkg::BIN_INDEX_BITS;

  // input word
  logic [1:0]                   kind_q;
  logic [kpsa_pkg::KEY_W-1:0]   key_q;
  logic [kpsa_pkg::LEN_W-1:0]   len_q;
  logic [kpsa_pkg::SLOT_W-1:0]  pslot_q;
  logic [kpsa_pkg::TIME_W-1:0]  now_q;
  logic [kpsa_pkg::TMO_W-1:0]   tmo_q;
  logic [ID_W-1:0]              rid_q;
  logic [BIB-1:0]               bin_q;
  logic [kpsa_pkg::LEN_W-1:0]   len_in;

  // record state
  logic [RC-1:0]   used_q;
  logic [LW-1:0]   newer_q [RC];
  logic [LW-1:0]   older_q [RC];
  logic [LW-1:0]   head_q, tail_q;
  logic [ID_W-1:0] cur_q;
  logic [BIB-1:0]  rm_bin_q;
  logic [BIB-1:0]  clr_q;

  // query walk
  logic [BD-1:0][ID_W-1:0]     members_q;
  logic [FW-1:0]               qf_q, qi_q;
  logic [kpsa_pkg::CNT_W-1:0]  cnt_q;
  logic [ID_W-1:0]             member;

  // result register
  logic                         out_valid_q;
  logic [2:0]                   ev_q;
  logic [ID_W-1:0]              orec_q;
  logic [kpsa_pkg::SLOT_W-1:0]  oslot_q;
  logic [kpsa_pkg::CNT_W-1:0]   ocnt_q;
  logic                         olast_q;
  logic                         out_free;

  // memories
  logic                           rec_we, rec_re;
  logic [ID_W-1:0]                rec_waddr, rec_raddr;
  kpsa_pkg::rec_t                 rec_wr, rec_rd;
  logic [kpsa_pkg::REC_WORD_W-1:0] rec_rdata;
  logic                           bin_we, bin_re;
  logic [BIB-1:0]                 bin_waddr, bin_raddr;
  kpsa_pkg::bin_t                 bin_wr, bin_rd, bin_rm, bin_add;
  logic [kpsa_pkg::BIN_WORD_W-1:0] bin_rdata;

  logic            free_found;
  logic [ID_W-1:0] free_id;
  logic [FW-1:0]   rm_f;
  logic [BD-1:0]   rm_hit;
  logic            rm_seen;
  logic [LW-1:0]   cur_older, cur_newer;

  assign len_in    = kpsa_pkg::clamp_len(key_len_i);
  assign rec_rd    = rec_rdata;
  assign bin_rd    = bin_rdata;
  assign member    = members_q[qi_q[$clog2(BD)-1:0]];
  assign out_free  = !out_valid_q || out_ready_i;
  assign cur_older = older_q[cur_q];
  assign cur_newer = newer_q[cur_q];

  // lowest free record
  always_comb begin
    free_found = 1'b0;
    free_id    = '0;
    for (int i = RC - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_id    = ID_W'(i);
      end
    end
  end

  // bin word with current record taken out, later members moved down
  always_comb begin
    rm_f    = (bin_rd.fill > FW'(BD)) ? FW'(BD) : bin_rd.fill;
    bin_rm  = bin_rd;
    rm_seen = 1'b0;
    for (int j = 0; j < BD; j++) begin
      rm_hit[j] = (FW'(j) < rm_f) && (bin_rd.members[j] == cur_q);
    end
    for (int j = 0; j < BD - 1; j++) begin
      rm_seen = rm_seen | rm_hit[j];
      if (rm_seen) bin_rm.members[j] = bin_rd.members[j+1];
    end
    if (|rm_hit) bin_rm.fill = rm_f - FW'(1);
  end

  // bin word with current record appended
  always_comb begin
    bin_add = bin_rd;
    for (int j = 0; j < BD; j++) begin
      if (FW'(j) == bin_rd.fill) bin_add.members[j] = cur_q;
    end
    bin_add.fill = bin_rd.fill + FW'(1);
  end

  // record memory ports
  always_comb begin
    rec_re    = cmd_i.rd_head | cmd_i.rd_rid | cmd_i.q_rd_rec;
    rec_raddr = rid_q;
    if (cmd_i.rd_head)  rec_raddr = head_q[ID_W-1:0];
    if (cmd_i.q_rd_rec) rec_raddr = member;
    rec_we         = cmd_i.save_alloc;
    rec_waddr      = free_id;
    rec_wr.key     = key_q;
    rec_wr.len     = len_q;
    rec_wr.slot    = pslot_q;
    rec_wr.expiry  = kpsa_pkg::EXP_W'(now_q) + kpsa_pkg::EXP_W'(tmo_q);
  end

  // bin memory ports
  always_comb begin
    bin_re    = cmd_i.rm_link | cmd_i.save_alloc | cmd_i.q_rd;
    bin_raddr = cmd_i.rm_link ? rm_bin_q : bin_q;
    bin_we    = cmd_i.clr_step | cmd_i.rm_bin | (cmd_i.sv_bin & (bin_rd.fill < FW'(BD)));
    bin_waddr = bin_q;
    bin_wr    = bin_add;
    if (cmd_i.clr_step) begin
      bin_waddr = clr_q;
      bin_wr    = '0;
    end else if (cmd_i.rm_bin) begin
      bin_waddr = rm_bin_q;
      bin_wr    = bin_rm;
    end
  end

  kpsa_ram #(.WIDTH(kpsa_pkg::REC_WORD_W), .DEPTH(RC)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wr),
    .re_i    (rec_re),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  kpsa_ram #(.WIDTH(kpsa_pkg::BIN_WORD_W), .DEPTH(kpsa_pkg::BIN_COUNT)) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (bin_waddr),
    .wdata_i (bin_wr),
    .re_i    (bin_re),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  // input word capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= kpsa_pkg::KIND_SAVE;
    end else if (cmd_i.load_in) begin
      kind_q <= kind_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      key_q   <= kpsa_pkg::key_mask(key_i, len_in);
      len_q   <= len_in;
      pslot_q <= packet_slot_i;
      now_q   <= now_i;
      tmo_q   <= timeout_secs_i;
      rid_q   <= record_id_i;
      bin_q   <= kpsa_pkg::bin_of(kpsa_pkg::key_mask(key_i, len_in), len_in);
    end
  end

  // clear pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + BIB'(1);
    end
  end

  // age list and in-use bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      head_q <= kpsa_pkg::NONE_REC;
      tail_q <= kpsa_pkg::NONE_REC;
      for (int i = 0; i < RC; i++) begin
        newer_q[i] <= kpsa_pkg::NONE_REC;
        older_q[i] <= kpsa_pkg::NONE_REC;
      end
    end else if (cmd_i.rm_link) begin
      if (head_q == LW'(cur_q)) head_q <= cur_newer;
      if (tail_q == LW'(cur_q)) tail_q <= cur_older;
      if (cur_older < LW'(RC)) newer_q[cur_older[ID_W-1:0]] <= cur_newer;
      if (cur_newer < LW'(RC)) older_q[cur_newer[ID_W-1:0]] <= cur_older;
      newer_q[cur_q] <= kpsa_pkg::NONE_REC;
      older_q[cur_q] <= kpsa_pkg::NONE_REC;
      used_q[cur_q]  <= 1'b0;
    end else if (cmd_i.save_alloc) begin
      used_q[free_id]  <= 1'b1;
      newer_q[free_id] <= kpsa_pkg::NONE_REC;
      older_q[free_id] <= tail_q;
      if (tail_q < LW'(RC)) newer_q[tail_q[ID_W-1:0]] <= LW'(free_id);
      else                  head_q <= LW'(free_id);
      tail_q <= LW'(free_id);
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_head)    cur_q <= head_q[ID_W-1:0];
    if (cmd_i.rd_rid)     cur_q <= rid_q;
    if (cmd_i.save_alloc) cur_q <= free_id;
    if (cmd_i.q_rd_rec)   cur_q <= member;
    if (cmd_i.latch_rm)   rm_bin_q <= kpsa_pkg::bin_of(rec_rd.key, rec_rd.len);
    if (cmd_i.q_load) begin
      members_q <= bin_rd.members;
      qf_q      <= (bin_rd.fill > FW'(BD)) ? FW'(BD) : bin_rd.fill;
      qi_q      <= '0;
      cnt_q     <= '0;
    end
    if (cmd_i.q_skip || cmd_i.q_hit) qi_q <= qi_q + FW'(1);
    if (cmd_i.q_hit) cnt_q <= cnt_q + kpsa_pkg::CNT_W'(1);
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ev_q    <= cmd_i.ev;
      orec_q  <= cur_q;
      oslot_q <= rec_rd.slot;
      ocnt_q  <= '0;
      olast_q <= !(cmd_i.ev == kpsa_pkg::EV_EXPIRED || cmd_i.ev == kpsa_pkg::EV_MATCH);
      case (cmd_i.ev)
        kpsa_pkg::EV_SAVED, kpsa_pkg::EV_UNINDEXED: oslot_q <= pslot_q;
        kpsa_pkg::EV_NO_FREE: begin
          orec_q  <= '0;
          oslot_q <= pslot_q;
        end
        kpsa_pkg::EV_QDONE: begin
          orec_q  <= '0;
          oslot_q <= '0;
          ocnt_q  <= cnt_q;
        end
        kpsa_pkg::EV_NOT_USED: begin
          orec_q  <= rid_q;
          oslot_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = ev_q;
  assign result_record_o = orec_q;
  assign result_slot_o   = oslot_q;
  assign match_count_o   = ocnt_q;
  assign last_o          = olast_q;

  // status to controller
  always_comb begin
    stat_o            = '0;
    stat_o.clr_last   = &clr_q;
    stat_o.kind       = kind_q;
    stat_o.head_none  = !(head_q < LW'(RC));
    stat_o.expired    = {1'b0, now_q} > rec_rd.expiry;
    stat_o.rid_used   = used_q[rid_q];
    stat_o.free_found = free_found;
    stat_o.bin_full   = !(bin_rd.fill < FW'(BD));
    stat_o.q_more     = (qi_q < qf_q) && (cnt_q < kpsa_pkg::CNT_W'(kpsa_pkg::QUERY_LIMIT));
    stat_o.q_used     = used_q[member];
    stat_o.q_match    = (rec_rd.len == len_q) && (rec_rd.key == key_q);
    stat_o.out_free   = out_free;
  end

  `KPSA_ASSERT(a_list_ends, (head_q == kpsa_pkg::NONE_REC) == (tail_q == kpsa_pkg::NONE_REC), "age list head and tail disagree on empty")
  `KPSA_ASSERT(a_unlink_frees, cmd_i.rm_link |=> !used_q[cur_q], "removed record still in use")
  `KPSA_NEVER(a_emit_blocked, cmd_i.emit && !out_free, "result loaded over an untaken word")
  `KPSA_NEVER(a_alloc_full, cmd_i.save_alloc && !free_found, "record allocated with none free")

endmodule

FILE: hw/rtl/keyed_packet_store_with_aging_top.sv
// Top level of the keyed packet store with aging.
// Depends on kpsa_pkg, kpsa_if, kpsa_ctrl, kpsa_dp (with kpsa_ram).

// Stores up to 32 packet slots under keys of 1 to 8 bytes, in 1024 hash bins of
// eight members, with the records kept on an age list. While the bin memory
// is cleared after reset, no word is accepted. Items are worked one at a time
// through a record memory and a bin memory, each with one write port and one
// read port with registered reads: a free unlinks the record and takes it out
// of its bin, a query walks the bin members, skipping unused ones and comparing
// used ones, and a save first frees each expired record at the head of the age
// list. A result waits in an output register while the next word is accepted;
// results of one item come in order, the last one flagged.
module keyed_packet_store_with_aging_top (
  input logic        clk_i,
  input logic        rst_ni,
  kpsa_in_if.sink    item_i,
  kpsa_out_if.source result_o
);

  kpsa_pkg::ctrl_cmd_t cmd;
  kpsa_pkg::dp_stat_t  stat;

  kpsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_kind_i  (item_i.kind),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kpsa_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (item_i.kind),
    .key_i           (item_i.key),
    .key_len_i       (item_i.key_len),
    .packet_slot_i   (item_i.packet_slot),
    .now_i           (item_i.now),
    .timeout_secs_i  (item_i.timeout_secs),
    .record_id_i     (item_i.record_id),
    .out_valid_o     (result_o.valid),
    .out_ready_i     (result_o.ready),
    .event_res_o     (result_o.event_res),
    .result_record_o (result_o.result_record),
    .result_slot_o   (result_o.result_slot),
    .match_count_o   (result_o.match_count),
    .last_o          (result_o.last)
  );

endmodule
